/* rtl/core/serial_angle_command_servo_pwm_top_defines.svh */
`ifndef SERIAL_ANGLE_COMMAND_SERVO_PWM_TOP_DEFINES_SVH
`define SERIAL_ANGLE_COMMAND_SERVO_PWM_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising edge of clock.
`define SACSP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising edge of clock.
`define SACSP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/sacsp_pkg.sv */
`timescale 1ns / 1ps

package sacsp_pkg;

   localparam int LINE_SLOTS_DEF = 7;

   localparam int US_W    = 14;
   localparam int TICK_W  = 16;
   localparam int HIGH_W  = 15;
   localparam int ANGLE_W = 8;
   localparam int PROD_W  = ANGLE_W + US_W;
   localparam int CSR_W   = 2;

   localparam logic [US_W-1:0]   MIN_PULSE_RST = 14'd600;
   localparam logic [US_W-1:0]   MAX_PULSE_RST = 14'd2400;
   localparam logic [TICK_W-1:0] FRAME_RST     = 16'd40000;
   localparam logic [HIGH_W-1:0] HIGH_RST      = 15'd3000;
   localparam logic [TICK_W-1:0] PHASE_RST     = 16'd3000;
   localparam logic [HIGH_W-1:0] HIGH_SAT      = 15'd32767;

   localparam logic [11:0] ANGLE_MAX = 12'd180;

   // floor(p / 180) = floor((p >> 2) * RECIP >> SHIFT) for all p below 2**22
   localparam int              DIV_SHIFT = 26;
   localparam logic [20:0]     DIV_RECIP = 21'd1491309;

   localparam logic [7:0] CHAR_LF    = 8'd10;
   localparam logic [7:0] CHAR_CR    = 8'd13;
   localparam logic [7:0] CHAR_BS    = 8'd8;
   localparam logic [7:0] CHAR_DEL   = 8'd127;
   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_NINE  = 8'd57;

   localparam logic [CSR_W-1:0] CSR_MIN_PULSE = 2'd0;
   localparam logic [CSR_W-1:0] CSR_MAX_PULSE = 2'd1;
   localparam logic [CSR_W-1:0] CSR_FRAME     = 2'd2;

   typedef enum logic [2:0] {
      EV_NONE     = 3'd0,
      EV_MOVED    = 3'd1,
      EV_BAD      = 3'd2,
      EV_TOO_LONG = 3'd3,
      EV_ERASED   = 3'd4,
      EV_IGNORED  = 3'd5
   } event_type;

   typedef struct packed {
      logic       func;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic              servo_level;
      logic              echo_valid;
      logic [7:0]        echo_byte;
      event_type         event_code;
      logic [ANGLE_W-1:0] new_angle;
      logic [HIGH_W-1:0] high_ticks;
   } rsp_type;

   // Line editor result on its way to the pulse stage
   typedef struct packed {
      logic               is_tick;
      logic               echo_valid;
      logic [7:0]         echo_byte;
      event_type          event_code;
      logic [ANGLE_W-1:0] new_angle;
      logic [PROD_W-1:0]  product;
   } mid_type;

endpackage

/* rtl/core/sacsp_line_edit.sv */
`timescale 1ns / 1ps
`include "serial_angle_command_servo_pwm_top_defines.svh"

module sacsp_line_edit #(
   parameter int LineSlots = sacsp_pkg::LINE_SLOTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fire,
   input  sacsp_pkg::req_type            item,
   input  logic [sacsp_pkg::US_W-1:0]    min_pulse_us,
   input  logic [sacsp_pkg::US_W-1:0]    max_pulse_us,
   output sacsp_pkg::mid_type            mid_data
);

   localparam int CW = $clog2(LineSlots + 1);
   localparam int IW = $clog2(LineSlots);

   // Entry i holds the running parse of characters 0..i of the line
   logic [sacsp_pkg::ANGLE_W-1:0] val_ff [LineSlots];
   logic                          bad_ff [LineSlots];
   logic [CW-1:0]                 count_ff, count_in;
   sacsp_pkg::mid_type            mid_ff, mid_in;

   logic [IW-1:0]                 rd_idx, wr_idx;
   logic [sacsp_pkg::ANGLE_W-1:0] prev_val;
   logic                          prev_bad;
   logic [11:0]                   acc;
   logic                          new_bad;
   logic                          is_eol, is_bs, is_digit;
   logic                          wr_en;
   logic [sacsp_pkg::US_W-1:0]    span;

   assign rd_idx   = IW'(count_ff - CW'(1));
   assign wr_idx   = count_ff[IW-1:0];
   assign prev_val = (count_ff == '0) ? '0 : val_ff[rd_idx];
   assign prev_bad = (count_ff != '0) && bad_ff[rd_idx];

   assign is_eol   = (item.rx_byte == sacsp_pkg::CHAR_CR) || (item.rx_byte == sacsp_pkg::CHAR_LF);
   assign is_bs    = (item.rx_byte == sacsp_pkg::CHAR_BS) || (item.rx_byte == sacsp_pkg::CHAR_DEL);
   assign is_digit = item.rx_byte inside {[sacsp_pkg::CHAR_ZERO:sacsp_pkg::CHAR_NINE]};

   // Low nibble of an ASCII digit is its value
   assign acc     = 12'(prev_val) * 12'd10 + 12'(item.rx_byte[3:0]);
   assign new_bad = prev_bad || !is_digit || (acc > sacsp_pkg::ANGLE_MAX);

   assign span = (max_pulse_us > min_pulse_us) ? (max_pulse_us - min_pulse_us) : '0;

   always_comb begin
      count_in            = count_ff;
      wr_en               = 1'b0;
      mid_in.is_tick      = item.func;
      mid_in.echo_valid   = !item.func;
      mid_in.echo_byte    = item.func ? 8'd0 : item.rx_byte;
      mid_in.event_code   = sacsp_pkg::EV_NONE;
      mid_in.new_angle    = '0;
      mid_in.product      = '0;
      if (!item.func) begin
         if (is_eol) begin
            if (count_ff == '0) begin
               mid_in.event_code = sacsp_pkg::EV_IGNORED;
            end else begin
               if (!prev_bad) begin
                  mid_in.event_code = sacsp_pkg::EV_MOVED;
                  mid_in.new_angle  = prev_val;
                  mid_in.product    = sacsp_pkg::PROD_W'(prev_val) *
                                      sacsp_pkg::PROD_W'(span);
               end else begin
                  mid_in.event_code = sacsp_pkg::EV_BAD;
               end
               count_in = '0;
            end
         end else if (is_bs) begin
            if (count_ff != '0) begin
               count_in          = count_ff - CW'(1);
               mid_in.event_code = sacsp_pkg::EV_ERASED;
            end
         end else if (count_ff < CW'(LineSlots)) begin
            wr_en    = 1'b1;
            count_in = count_ff + CW'(1);
         end else begin
            // overflow: drop the whole line
            count_in          = '0;
            mid_in.event_code = sacsp_pkg::EV_TOO_LONG;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (fire) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && wr_en) begin
         val_ff[wr_idx] <= acc[sacsp_pkg::ANGLE_W-1:0];
         bad_ff[wr_idx] <= new_bad;
      end
      if (fire) begin
         mid_ff <= mid_in;
      end
   end

   assign mid_data = mid_ff;

   `SACSP_ASSERT_NEXT(a_eol_clears_line, fire && !item.func && is_eol, count_ff == '0,
      "line end did not empty the line")
   `SACSP_ASSERT_NOW(a_count_in_range, fire, count_in <= CW'(LineSlots),
      "character count beyond line size")
   `SACSP_ASSERT_NEXT(a_tick_keeps_line, fire && item.func, $stable(count_ff),
      "timer tick changed the line")

endmodule

/* rtl/core/sacsp_pulse_gen.sv */
`timescale 1ns / 1ps
`include "serial_angle_command_servo_pwm_top_defines.svh"

module sacsp_pulse_gen (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fire,
   input  sacsp_pkg::mid_type            mid_data,
   input  logic [sacsp_pkg::US_W-1:0]    min_pulse_us,
   input  logic [sacsp_pkg::TICK_W-1:0]  frame_ticks,
   output sacsp_pkg::rsp_type            rsp_data
);

   logic [sacsp_pkg::HIGH_W-1:0] high_ff, high_in;
   logic                         pin_ff, pin_in;
   logic [sacsp_pkg::TICK_W-1:0] cnt_ff, cnt_in;
   logic [sacsp_pkg::TICK_W-1:0] len_ff, len_in;
   sacsp_pkg::rsp_type           out_ff, out_in;

   logic [19:0]                  quarter;
   logic [41:0]                  scaled;
   logic [sacsp_pkg::US_W-1:0]   quot;
   logic [sacsp_pkg::HIGH_W-1:0] pulse_us;
   logic [sacsp_pkg::TICK_W-1:0] pulse_ticks;
   logic [sacsp_pkg::TICK_W:0]   cnt_next;
   logic [sacsp_pkg::TICK_W-1:0] high_ext;

   // angle * span / 180 by reciprocal
   assign quarter     = mid_data.product[sacsp_pkg::PROD_W-1:2];
   assign scaled      = 42'(quarter) * 42'(sacsp_pkg::DIV_RECIP);
   assign quot        = scaled[sacsp_pkg::DIV_SHIFT +: sacsp_pkg::US_W];
   assign pulse_us    = sacsp_pkg::HIGH_W'(min_pulse_us) + sacsp_pkg::HIGH_W'(quot);
   assign pulse_ticks = {pulse_us, 1'b0};

   assign cnt_next = (sacsp_pkg::TICK_W + 1)'(cnt_ff) + 17'd1;
   assign high_ext = sacsp_pkg::TICK_W'(high_ff);

   always_comb begin
      high_in = high_ff;
      pin_in  = pin_ff;
      cnt_in  = cnt_ff;
      len_in  = len_ff;
      if (!mid_data.is_tick && (mid_data.event_code == sacsp_pkg::EV_MOVED)) begin
         high_in = pulse_ticks[sacsp_pkg::TICK_W-1] ? sacsp_pkg::HIGH_SAT :
                   pulse_ticks[sacsp_pkg::HIGH_W-1:0];
      end
      if (mid_data.is_tick) begin
         if (cnt_next >= (sacsp_pkg::TICK_W + 1)'(len_ff)) begin
            cnt_in = '0;
            if (pin_ff) begin
               pin_in = 1'b0;
               len_in = (frame_ticks > high_ext) ? (frame_ticks - high_ext) :
                        sacsp_pkg::TICK_W'(1);
            end else begin
               pin_in = 1'b1;
               len_in = high_ext;
            end
         end else begin
            cnt_in = cnt_next[sacsp_pkg::TICK_W-1:0];
         end
      end
   end

   always_comb begin
      out_in.servo_level = pin_in;
      out_in.echo_valid  = mid_data.echo_valid;
      out_in.echo_byte   = mid_data.echo_byte;
      out_in.event_code  = mid_data.event_code;
      out_in.new_angle   = mid_data.new_angle;
      out_in.high_ticks  = high_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_ff <= sacsp_pkg::HIGH_RST;
         pin_ff  <= 1'b1;
         cnt_ff  <= '0;
         len_ff  <= sacsp_pkg::PHASE_RST;
      end else if (fire) begin
         high_ff <= high_in;
         pin_ff  <= pin_in;
         cnt_ff  <= cnt_in;
         len_ff  <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_ff <= out_in;
      end
   end

   assign rsp_data = out_ff;

   `SACSP_ASSERT_NOW(a_counter_in_phase, 1'b1, (cnt_ff < len_ff) || (cnt_ff == '0),
      "phase counter past phase length")
   `SACSP_ASSERT_NEXT(a_byte_keeps_timer, fire && !mid_data.is_tick,
      $stable(pin_ff) && $stable(cnt_ff) && $stable(len_ff),
      "received byte disturbed the servo timer")
   `SACSP_ASSERT_NEXT(a_tick_keeps_pulse, fire && mid_data.is_tick, $stable(high_ff),
      "timer tick changed the pulse width")

endmodule

/* rtl/core/serial_angle_command_servo_pwm_top.sv */
`timescale 1ns / 1ps
`include "serial_angle_command_servo_pwm_top_defines.svh"
// A result is presented once its transaction has passed the pipeline registers in order
// (input register loads at accept, then line editor register, then pulse/result register).
// Throughput: one transaction per cycle unless stalled; each stage is a single short pass.
// Stalls back up stage by stage; empty stages keep accepting.
// Reset (synchronous, active high): empty line, 3000-tick pulse, pin high,
// registers at 600 us / 2400 us / 40000 ticks.

module serial_angle_command_servo_pwm_top #(
   parameter int LineSlots = sacsp_pkg::LINE_SLOTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  sacsp_pkg::req_type            req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output sacsp_pkg::rsp_type            rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [sacsp_pkg::CSR_W-1:0]   csr_index,
   input  logic [sacsp_pkg::TICK_W-1:0]  csr_wdata
);

   logic [sacsp_pkg::US_W-1:0]   min_ff, max_ff;
   logic [sacsp_pkg::TICK_W-1:0] frame_ff;

   logic               in_v_ff, mid_v_ff, out_v_ff;
   sacsp_pkg::req_type in_ff;
   sacsp_pkg::mid_type mid_data;

   logic out_adv, mid_adv, in_adv;
   logic in_fire, mid_fire, req_fire;

   assign out_adv  = !out_v_ff || !rsp_stall;
   assign mid_adv  = !mid_v_ff || out_adv;
   assign in_adv   = !in_v_ff || mid_adv;
   assign mid_fire = mid_v_ff && out_adv;
   assign in_fire  = in_v_ff && mid_adv;
   assign req_stall = !in_adv;
   assign req_fire  = req_valid && in_adv;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff   <= sacsp_pkg::MIN_PULSE_RST;
         max_ff   <= sacsp_pkg::MAX_PULSE_RST;
         frame_ff <= sacsp_pkg::FRAME_RST;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == sacsp_pkg::CSR_MIN_PULSE) begin
            min_ff <= csr_wdata[sacsp_pkg::US_W-1:0];
         end else if (csr_index == sacsp_pkg::CSR_MAX_PULSE) begin
            max_ff <= csr_wdata[sacsp_pkg::US_W-1:0];
         end else if (csr_index == sacsp_pkg::CSR_FRAME) begin
            frame_ff <= csr_wdata;
         end
      end
   end

   // advance valid bits wherever the stage ahead frees up
   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff  <= 1'b0;
         mid_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (in_adv) begin
            in_v_ff <= req_valid;
         end
         if (mid_adv) begin
            mid_v_ff <= in_v_ff;
         end
         if (out_adv) begin
            out_v_ff <= mid_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_ff <= req_data;
      end
   end

   sacsp_line_edit #(
      .LineSlots(LineSlots)
   ) u_line_edit (
      .clock        (clock),
      .reset        (reset),
      .fire         (in_fire),
      .item         (in_ff),
      .min_pulse_us (min_ff),
      .max_pulse_us (max_ff),
      .mid_data     (mid_data)
   );

   sacsp_pulse_gen u_pulse_gen (
      .clock        (clock),
      .reset        (reset),
      .fire         (mid_fire),
      .mid_data     (mid_data),
      .min_pulse_us (min_ff),
      .frame_ticks  (frame_ff),
      .rsp_data     (rsp_data)
   );

   assign rsp_valid = out_v_ff;

   `SACSP_ASSERT_NOW(a_stall_only_when_full, req_stall,
      in_v_ff && mid_v_ff && out_v_ff && rsp_stall,
      "input stalled with a free stage")
   `SACSP_ASSERT_NEXT(a_accept_loads_input, req_fire, in_v_ff,
      "accepted transaction not held in input stage")
   `SACSP_ASSERT_NEXT(a_mid_moves_out, mid_fire, out_v_ff,
      "transaction lost between line editor and result stage")

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;
   import sacsp_pkg::*;

   localparam logic [CSR_W-1:0] CSR_UNUSED = 2'd3;
   localparam int NUM_PHASES   = 8;
   localparam int PHASE_ITEMS  = 200;
   localparam int PRESS_PHASE  = 4;
   localparam int HOLD_CYCLES  = 80;
   localparam int DRAIN_CYCLES = 6;
   localparam int STALL_LIMIT  = 2000;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type want;
   } row_type;

   logic                clock;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   req_type             req_data  = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   rsp_type             rsp_data;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CSR_W-1:0]    csr_index = '0;
   logic [TICK_W-1:0]   csr_wdata = '0;

   // predictor state and register copies
   logic [7:0]          line_chars [LINE_SLOTS_DEF];
   logic [2:0]          line_len;
   logic [HIGH_W-1:0]   pulse_ticks;
   logic                pin;
   logic [TICK_W-1:0]   phase_cnt;
   logic [TICK_W-1:0]   phase_len;
   logic [US_W-1:0]     cfg_min;
   logic [US_W-1:0]     cfg_max;
   logic [TICK_W-1:0]   cfg_frame;

   rsp_type             servo_rsp_due [$];
   row_type             directed_rows [$];
   req_type             phase_items [$];
   bit                  typed_now = 1'b0;
   rsp_type             typed_rsp = '0;
   int                  error_count = 0;
   int                  idle_cycles = 0;
   int                  snd_burst = 0;
   int                  rcv_burst = 0;
   int                  rcv_hold = 0;

   serial_angle_command_servo_pwm_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic rsp_type servo_predict(input req_type item);
      rsp_type     res;
      logic [7:0]  b;
      int unsigned value, span, us, ticks, nxt, i;
      bit          ok;
      res = '0;
      b = item.rx_byte;
      if (item.func) begin
         nxt = phase_cnt + 1;
         if (nxt >= phase_len) begin
            phase_cnt = '0;
            if (pin) begin
               pin = 1'b0;
               phase_len = (cfg_frame > pulse_ticks) ? cfg_frame - pulse_ticks : 16'd1;
            end else begin
               pin = 1'b1;
               phase_len = pulse_ticks;
            end
         end else begin
            phase_cnt = nxt[TICK_W-1:0];
         end
      end else begin
         res.echo_valid = 1'b1;
         res.echo_byte  = b;
         if (b == CHAR_CR || b == CHAR_LF) begin
            if (line_len == 0) begin
               res.event_code = EV_IGNORED;
            end else begin
               ok = 1'b1;
               value = 0;
               for (i = 0; i < line_len; i++) begin
                  if (ok) begin
                     if (line_chars[i] < CHAR_ZERO || line_chars[i] > CHAR_NINE) begin
                        ok = 1'b0;
                     end else begin
                        value = value * 10 + (line_chars[i] - CHAR_ZERO);
                        if (value > ANGLE_MAX) ok = 1'b0;
                     end
                  end
               end
               if (ok) begin
                  span  = (cfg_max > cfg_min) ? cfg_max - cfg_min : 0;
                  us    = cfg_min + (value * span) / ANGLE_MAX;
                  ticks = us * 2;
                  pulse_ticks = (ticks > HIGH_SAT) ? HIGH_SAT : ticks[HIGH_W-1:0];
                  res.new_angle  = value[ANGLE_W-1:0];
                  res.event_code = EV_MOVED;
               end else begin
                  res.event_code = EV_BAD;
               end
               line_len = '0;
            end
         end else if (b == CHAR_BS || b == CHAR_DEL) begin
            if (line_len > 0) begin
               line_len = line_len - 1;
               res.event_code = EV_ERASED;
            end
         end else if (line_len < LINE_SLOTS_DEF) begin
            line_chars[line_len] = b;
            line_len = line_len + 1;
         end else begin
            line_len = '0;
            res.event_code = EV_TOO_LONG;
         end
      end
      res.servo_level = pin;
      res.high_ticks  = pulse_ticks;
      return res;
   endfunction

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (servo_rsp_due.size() == 0) begin
         $display("%0t: result with nothing expected, got %h", $time, got);
         error_count++;
      end else begin
         want = servo_rsp_due.pop_front();
         check_field("servo_level", want.servo_level, got.servo_level);
         check_field("echo_valid", want.echo_valid, got.echo_valid);
         check_field("echo_byte", want.echo_byte, got.echo_byte);
         check_field("event_code", int'(want.event_code), int'(got.event_code));
         check_field("new_angle", want.new_angle, got.new_angle);
         check_field("high_ticks", want.high_ticks, got.high_ticks);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LINE_SLOTS_DEF; i++) line_chars[i] <= '0;
         line_len    <= '0;
         pulse_ticks <= HIGH_RST;
         pin         <= 1'b1;
         phase_cnt   <= '0;
         phase_len   <= PHASE_RST;
         cfg_min     <= MIN_PULSE_RST;
         cfg_max     <= MAX_PULSE_RST;
         cfg_frame   <= FRAME_RST;
      end else begin
         if (rsp_valid && !rsp_stall) check_result(rsp_data);
         if (req_valid && !req_stall) begin
            if (typed_now) begin
               void'(servo_predict(req_data));
               servo_rsp_due.push_back(typed_rsp);
            end else begin
               servo_rsp_due.push_back(servo_predict(req_data));
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MIN_PULSE: cfg_min   = csr_wdata[US_W-1:0];
               CSR_MAX_PULSE: cfg_max   = csr_wdata[US_W-1:0];
               CSR_FRAME:     cfg_frame = csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // watchdog: cycles with no transaction on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int draw_gap(inout int burst);
      if (burst > 0) begin
         burst--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) burst = $urandom_range(8, 40);
      return $urandom_range(0, 17);
   endfunction

   // receiver: random stall before each result, one long hold on request
   initial begin : receiver
      int gap;
      forever begin
         @(negedge clock);
         gap = draw_gap(rcv_burst);
         if (rcv_hold > 0) begin
            gap = rcv_hold;
            rcv_hold = 0;
         end
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   task automatic send_item(input req_type item, input bit typed, input rsp_type want);
      int gap;
      gap = draw_gap(snd_burst);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      typed_now = typed;
      typed_rsp = want;
      do @(posedge clock); while (req_stall);
   endtask

   // hold input off until every result is back
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      typed_now = 1'b0;
      while (servo_rsp_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_W-1:0] idx, input logic [TICK_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic row_pred(input logic func, input logic [7:0] b);
      row_type r;
      r.req.func = func;
      r.req.rx_byte = b;
      r.typed = 1'b0;
      r.want = '0;
      directed_rows.push_back(r);
   endtask

   task automatic row_known(input logic func, input logic [7:0] b, input logic level,
                            input event_type ev, input logic [7:0] angle,
                            input logic [HIGH_W-1:0] high);
      row_type r;
      r.req.func = func;
      r.req.rx_byte = b;
      r.typed = 1'b1;
      r.want.servo_level = level;
      r.want.echo_valid  = !func;
      r.want.echo_byte   = func ? 8'd0 : b;
      r.want.event_code  = ev;
      r.want.new_angle   = angle;
      r.want.high_ticks  = high;
      directed_rows.push_back(r);
   endtask

   task automatic put_tick();
      req_type item;
      item.func = 1'b1;
      item.rx_byte = $urandom_range(0, 255);
      phase_items.push_back(item);
   endtask

   task automatic put_char(input int b);
      req_type item;
      if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 3)) put_tick();
      item.func = 1'b0;
      item.rx_byte = b[7:0];
      phase_items.push_back(item);
   endtask

   function automatic int line_end();
      return ($urandom_range(0, 1) == 0) ? CHAR_CR : CHAR_LF;
   endfunction

   task automatic gen_phase(input int target);
      int kind, angle, ndig, pad, i;
      int digs [3];
      phase_items.delete();
      while (phase_items.size() < target) begin
         kind = $urandom_range(0, 99);
         if (kind < 60) begin
            // angle command with random zeros, edits and ticks
            angle = ($urandom_range(0, 9) == 0) ? $urandom_range(181, 999)
                                                : $urandom_range(0, 180);
            digs[0] = angle / 100;
            digs[1] = (angle / 10) % 10;
            digs[2] = angle % 10;
            ndig = (angle >= 100) ? 3 : (angle >= 10) ? 2 : 1;
            pad = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7 - ndig) : 0;
            repeat (pad) put_char(CHAR_ZERO);
            for (i = 3 - ndig; i < 3; i++) begin
               if ($urandom_range(0, 11) == 0) begin
                  put_char(CHAR_ZERO + $urandom_range(0, 9));
                  put_char(($urandom_range(0, 1) == 0) ? CHAR_BS : CHAR_DEL);
               end
               put_char(CHAR_ZERO + digs[i]);
            end
            put_char(line_end());
         end else if (kind < 72) begin
            repeat ($urandom_range(6, 10)) put_char($urandom_range(32, 126));
            put_char(line_end());
         end else if (kind < 84) begin
            repeat ($urandom_range(1, 4)) put_char($urandom_range(0, 255));
         end else begin
            repeat ($urandom_range(1, 24)) put_tick();
         end
      end
   endtask

   initial begin : stimulus
      int p;
      logic [TICK_W-1:0] v_min, v_max, v_frame;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      row_known(1'b1, 8'd0, 1'b1, EV_NONE, 8'd0, 15'd3000);
      row_known(1'b0, CHAR_BS, 1'b1, EV_NONE, 8'd0, 15'd3000);
      row_known(1'b0, CHAR_CR, 1'b1, EV_IGNORED, 8'd0, 15'd3000);
      row_pred(1'b0, "1");
      row_pred(1'b0, "8");
      row_pred(1'b0, "0");
      row_known(1'b0, CHAR_LF, 1'b1, EV_MOVED, 8'd180, 15'd4800);
      row_pred(1'b0, "0");
      row_pred(1'b0, "0");
      row_known(1'b0, CHAR_CR, 1'b1, EV_MOVED, 8'd0, 15'd1200);
      // running value passes 180 on the last digit
      row_pred(1'b0, "1");
      row_pred(1'b0, "8");
      row_pred(1'b0, "1");
      row_known(1'b0, CHAR_CR, 1'b1, EV_BAD, 8'd0, 15'd1200);
      row_pred(1'b0, 8'hFF);
      row_known(1'b0, CHAR_BS, 1'b1, EV_ERASED, 8'd0, 15'd1200);
      row_pred(1'b0, 8'h00);
      row_known(1'b0, CHAR_CR, 1'b1, EV_BAD, 8'd0, 15'd1200);
      for (int i = 0; i < LINE_SLOTS_DEF; i++) row_pred(1'b0, 8'd49 + i);
      row_known(1'b0, "x", 1'b1, EV_TOO_LONG, 8'd0, 15'd1200);
      row_pred(1'b0, CHAR_LF);

      foreach (directed_rows[i])
         send_item(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

      for (p = 1; p < NUM_PHASES; p++) begin
         settle();
         case (p)
            1: begin v_min = 16'd0;     v_max = 16'd10000; v_frame = 16'd65535; end
            2: begin v_min = 16'd10000; v_max = 16'd0;     v_frame = 16'd1;     end
            3: begin v_min = 16'd0;     v_max = 16'd0;     v_frame = 16'd3;     end
            default: begin
               v_min   = $urandom_range(0, 20);
               v_max   = $urandom_range(0, 60);
               v_frame = $urandom_range(1, 120);
            end
         endcase
         csr_write(CSR_UNUSED, $urandom_range(0, 65535));
         csr_write(CSR_MIN_PULSE, v_min);
         csr_write(CSR_MAX_PULSE, v_max);
         csr_write(CSR_FRAME, v_frame);
         @(negedge clock);
         csr_valid <= 1'b0;

         gen_phase(PHASE_ITEMS);
         if (p == PRESS_PHASE) begin
            // back-to-back input against a long output hold
            snd_burst = 100;
            rcv_hold  = HOLD_CYCLES;
         end
         foreach (phase_items[i]) send_item(phase_items[i], 1'b0, '0);
      end

      settle();
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
